### design/bfse_pkg.sv
// ============================================================================
// bfse_pkg
// Shared types, field widths, command characters and controller states for
// the Brainfuck step engine.
// ============================================================================
package bfse_pkg;

  // Default store sizes
  localparam int TAPE_CELLS_DEF = 4096;
  localparam int PROG_BYTES_DEF = 4096;

  // Fixed field widths of the item and result words and of a tape cell
  localparam int ADDR_W = 12;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 32;
  localparam int CNT_W  = 32;

  // Item operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Command characters
  localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;  // '-'
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;  // '<'
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;  // '.'
  localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;  // ','
  localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5B;  // '['
  localparam logic [BYTE_W-1:0] CH_RBR   = 8'h5D;  // ']'

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FETCH,
    ST_EXEC,
    ST_SCAN,
    ST_POST
  } state_t;

  // Result word handed from the controller to the output register
  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] obyte;
    logic [BYTE_W-1:0] token;
    logic [ADDR_W-1:0] new_pc;
    logic [CNT_W-1:0]  steps;
    logic              err;
  } res_t;

endpackage

### design/brainfuck_step_engine.sv
// ============================================================================
// brainfuck_step_engine
// Brainfuck machine: program store and 32-bit tape in synchronous memories,
// one load or one executed command per item, one result word per item.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   opcode, prog_addr, prog_byte,
//                                           in_byte, in_eof
//   out_     output     out_valid/out_stall out_valid, out_byte, last_token,
//                                           new_pc, step_total, scan_error
//
// A load word passes through the LOAD and POST states and a step word through
// FETCH, EXEC and POST before its result enters the output register; the next
// word is taken once the controller is back in IDLE. A bracket scan adds the
// SCAN state, walking one program byte per cycle as set by the single
// program store read port. After reset both memories are zero-filled, and
// in_stall stays high until both sweeps are done.
// The result register lets the next word in while a result waits on out_stall.
// ============================================================================
module brainfuck_step_engine #(
  parameter int TAPE_CELLS = bfse_pkg::TAPE_CELLS_DEF,
  parameter int PROG_BYTES = bfse_pkg::PROG_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [bfse_pkg::ADDR_W-1:0] in_prog_addr,
  input  logic [bfse_pkg::BYTE_W-1:0] in_prog_byte,
  input  logic [bfse_pkg::BYTE_W-1:0] in_in_byte,
  input  logic                        in_in_eof,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_out_valid,
  output logic [bfse_pkg::BYTE_W-1:0] out_out_byte,
  output logic [bfse_pkg::BYTE_W-1:0] out_last_token,
  output logic [bfse_pkg::ADDR_W-1:0] out_new_pc,
  output logic [bfse_pkg::CNT_W-1:0]  out_step_total,
  output logic                        out_scan_error
);

  localparam int PA_W = $clog2(PROG_BYTES);
  localparam int TA_W = $clog2(TAPE_CELLS);

  logic                        prog_we;
  logic [PA_W-1:0]             prog_waddr;
  logic [bfse_pkg::BYTE_W-1:0] prog_wdata;
  logic [PA_W-1:0]             prog_raddr;
  logic [bfse_pkg::BYTE_W-1:0] prog_rdata;
  logic                        prog_busy;
  logic                        tape_we;
  logic [TA_W-1:0]             tape_waddr;
  logic [bfse_pkg::CELL_W-1:0] tape_wdata;
  logic [TA_W-1:0]             tape_raddr;
  logic [bfse_pkg::CELL_W-1:0] tape_rdata;
  logic                        tape_busy;

  logic                        res_vld;
  logic                        res_ready;
  bfse_pkg::res_t              res;
  bfse_pkg::res_t              res_r;
  logic                        ov_r;

  bfse_ram #(
    .DEPTH (PROG_BYTES),
    .WIDTH (bfse_pkg::BYTE_W)
  ) u_prog (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (prog_we),
    .waddr   (prog_waddr),
    .wdata   (prog_wdata),
    .raddr   (prog_raddr),
    .rd_data (prog_rdata),
    .busy    (prog_busy)
  );

  bfse_ram #(
    .DEPTH (TAPE_CELLS),
    .WIDTH (bfse_pkg::CELL_W)
  ) u_tape (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (tape_we),
    .waddr   (tape_waddr),
    .wdata   (tape_wdata),
    .raddr   (tape_raddr),
    .rd_data (tape_rdata),
    .busy    (tape_busy)
  );

  bfse_ctrl #(
    .TAPE_CELLS (TAPE_CELLS),
    .PROG_BYTES (PROG_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_prog_addr (in_prog_addr),
    .in_prog_byte (in_prog_byte),
    .in_in_byte   (in_in_byte),
    .in_in_eof    (in_in_eof),
    .clr_busy     (prog_busy || tape_busy),
    .res_vld      (res_vld),
    .res_ready    (res_ready),
    .res          (res),
    .prog_we      (prog_we),
    .prog_waddr   (prog_waddr),
    .prog_wdata   (prog_wdata),
    .prog_raddr   (prog_raddr),
    .prog_rdata   (prog_rdata),
    .tape_we      (tape_we),
    .tape_waddr   (tape_waddr),
    .tape_wdata   (tape_wdata),
    .tape_raddr   (tape_raddr),
    .tape_rdata   (tape_rdata)
  );

  // Output register: load when empty or being drained, hold while stalled
  assign res_ready = !ov_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (res_vld && res_ready) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_ready) begin
      res_r <= res;
    end
  end

  assign out_valid      = ov_r;
  assign out_out_valid  = res_r.emit;
  assign out_out_byte   = res_r.obyte;
  assign out_last_token = res_r.token;
  assign out_new_pc     = res_r.new_pc;
  assign out_step_total = res_r.steps;
  assign out_scan_error = res_r.err;

endmodule

### design/bfse_ram.sv
// ============================================================================
// bfse_ram
// Single write port, single read port memory with a registered read and
// a zero-fill sweep after reset, one entry per cycle.
// ============================================================================
module bfse_ram #(
  parameter int DEPTH = bfse_pkg::PROG_BYTES_DEF,
  parameter int WIDTH = bfse_pkg::BYTE_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data,
  output logic                     busy
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;
  logic [AW-1:0]    clr_r;
  logic             busy_r;

  // Sweep every entry once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      if (clr_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
      clr_r <= clr_r + 1'b1;
    end
  end

  // Write port (zero fill has priority) and registered read
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_r] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

### design/bfse_ctrl.sv
// ============================================================================
// bfse_ctrl
// Item sequencer and datapath: fetches from the program store, does the
// read-modify-write of the current tape cell and walks bracket scans one
// program byte per cycle.
// ============================================================================
module bfse_ctrl #(
  parameter int TAPE_CELLS = bfse_pkg::TAPE_CELLS_DEF,
  parameter int PROG_BYTES = bfse_pkg::PROG_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [bfse_pkg::ADDR_W-1:0]   in_prog_addr,
  input  logic [bfse_pkg::BYTE_W-1:0]   in_prog_byte,
  input  logic [bfse_pkg::BYTE_W-1:0]   in_in_byte,
  input  logic                          in_in_eof,
  // memories still sweeping
  input  logic                          clr_busy,
  // result hand-off
  output logic                          res_vld,
  input  logic                          res_ready,
  output bfse_pkg::res_t                res,
  // program store
  output logic                          prog_we,
  output logic [$clog2(PROG_BYTES)-1:0] prog_waddr,
  output logic [bfse_pkg::BYTE_W-1:0]   prog_wdata,
  output logic [$clog2(PROG_BYTES)-1:0] prog_raddr,
  input  logic [bfse_pkg::BYTE_W-1:0]   prog_rdata,
  // tape
  output logic                          tape_we,
  output logic [$clog2(TAPE_CELLS)-1:0] tape_waddr,
  output logic [bfse_pkg::CELL_W-1:0]   tape_wdata,
  output logic [$clog2(TAPE_CELLS)-1:0] tape_raddr,
  input  logic [bfse_pkg::CELL_W-1:0]   tape_rdata
);

  localparam int PA_W = $clog2(PROG_BYTES);
  localparam int TA_W = $clog2(TAPE_CELLS);
  localparam int DW   = PA_W + 1;

  localparam logic [PA_W-1:0] PC_LAST = PA_W'(PROG_BYTES - 1);
  localparam logic [TA_W-1:0] TI_LAST = TA_W'(TAPE_CELLS - 1);

  // Reduce a load address into the store by conditional subtraction
  function automatic logic [PA_W-1:0] wrap_addr(input logic [bfse_pkg::ADDR_W-1:0] a);
    logic [bfse_pkg::ADDR_W-1:0] r;
    longint                      lim;
    r = a;
    for (int k = bfse_pkg::ADDR_W - 1; k >= 0; k--) begin
      lim = longint'(PROG_BYTES) << k;
      if ((lim < (longint'(1) << bfse_pkg::ADDR_W)) && (longint'(r) >= lim)) begin
        r = r - bfse_pkg::ADDR_W'(lim);
      end
    end
    return PA_W'(r);
  endfunction

  function automatic logic [PA_W-1:0] pc_inc(input logic [PA_W-1:0] x);
    return (x == PC_LAST) ? '0 : x + 1'b1;
  endfunction

  bfse_pkg::state_t state_r, state_nxt;

  logic [PA_W-1:0]                 pc_r, pc_nxt;
  logic [PA_W-1:0]                 at_r, at_nxt;
  logic [PA_W-1:0]                 p_r, p_nxt;
  logic [DW-1:0]                   dep_r, dep_nxt;
  logic                            fwd_r, fwd_nxt;
  logic [TA_W-1:0]                 ti_r, ti_nxt;
  logic [bfse_pkg::CNT_W-1:0]      steps_r, steps_nxt;
  logic                            emit_r, emit_nxt;
  logic [bfse_pkg::BYTE_W-1:0]     obyte_r, obyte_nxt;
  logic [bfse_pkg::BYTE_W-1:0]     tok_r, tok_nxt;
  logic                            err_r, err_nxt;
  // latched item fields
  logic [bfse_pkg::ADDR_W-1:0]     ld_addr_r;
  logic [bfse_pkg::BYTE_W-1:0]     ld_byte_r;
  logic [bfse_pkg::BYTE_W-1:0]     ib_r;
  logic                            eof_r;

  logic                            in_acc;
  logic                            cell_zero;
  logic                            start_fwd;
  logic                            start_bwd;
  logic                            start_scan;
  logic [bfse_pkg::BYTE_W-1:0]     close_ch;
  logic [bfse_pkg::BYTE_W-1:0]     open_ch;
  logic [DW-1:0]                   scan_dep;
  logic                            scan_hit;
  logic                            scan_edge;

  // Handshake
  assign in_stall = (state_r != bfse_pkg::ST_IDLE) || clr_busy;
  assign in_acc   = in_valid && !in_stall;

  // Decode of the fetched byte and the scan cursor
  assign cell_zero  = (tape_rdata == '0);
  assign start_fwd  = (prog_rdata == bfse_pkg::CH_LBR) && cell_zero;
  assign start_bwd  = (prog_rdata == bfse_pkg::CH_RBR) && !cell_zero;
  assign start_scan = (start_fwd && (at_r != PC_LAST)) || (start_bwd && (at_r != '0));
  assign close_ch   = fwd_r ? bfse_pkg::CH_RBR : bfse_pkg::CH_LBR;
  assign open_ch    = fwd_r ? bfse_pkg::CH_LBR : bfse_pkg::CH_RBR;
  assign scan_dep   = (prog_rdata == close_ch) ? dep_r - 1'b1 :
                      (prog_rdata == open_ch)  ? dep_r + 1'b1 : dep_r;
  assign scan_hit   = (scan_dep == '0);
  assign scan_edge  = fwd_r ? (p_r == PC_LAST) : (p_r == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfse_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_opcode == bfse_pkg::OP_STEP) ? bfse_pkg::ST_FETCH
                                                       : bfse_pkg::ST_LOAD;
        end
      end
      bfse_pkg::ST_LOAD:  state_nxt = bfse_pkg::ST_POST;
      bfse_pkg::ST_FETCH: state_nxt = bfse_pkg::ST_EXEC;
      bfse_pkg::ST_EXEC: begin
        state_nxt = start_scan ? bfse_pkg::ST_SCAN : bfse_pkg::ST_POST;
      end
      bfse_pkg::ST_SCAN: begin
        if (scan_hit || scan_edge) begin
          state_nxt = bfse_pkg::ST_POST;
        end
      end
      bfse_pkg::ST_POST: begin
        if (res_ready) begin
          state_nxt = bfse_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfse_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    pc_nxt     = pc_r;
    at_nxt     = at_r;
    p_nxt      = p_r;
    dep_nxt    = dep_r;
    fwd_nxt    = fwd_r;
    ti_nxt     = ti_r;
    steps_nxt  = steps_r;
    emit_nxt   = emit_r;
    obyte_nxt  = obyte_r;
    tok_nxt    = tok_r;
    err_nxt    = err_r;
    prog_we    = 1'b0;
    prog_raddr = pc_r;
    tape_we    = 1'b0;
    tape_wdata = tape_rdata;
    res_vld    = 1'b0;
    unique case (state_r)
      bfse_pkg::ST_IDLE: ;
      bfse_pkg::ST_LOAD: begin
        // write the program byte; result carries no command
        prog_we   = 1'b1;
        emit_nxt  = 1'b0;
        obyte_nxt = '0;
        tok_nxt   = '0;
        err_nxt   = 1'b0;
      end
      bfse_pkg::ST_FETCH: begin
        // read program byte and current cell, advance pc, count the step
        prog_raddr = pc_r;
        at_nxt     = pc_r;
        pc_nxt     = pc_inc(pc_r);
        steps_nxt  = steps_r + 1'b1;
        emit_nxt   = 1'b0;
        obyte_nxt  = '0;
        err_nxt    = 1'b0;
      end
      bfse_pkg::ST_EXEC: begin
        tok_nxt = prog_rdata;
        unique case (prog_rdata)
          bfse_pkg::CH_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 1'b1;
          end
          bfse_pkg::CH_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 1'b1;
          end
          bfse_pkg::CH_LEFT:  ti_nxt = (ti_r == '0) ? TI_LAST : ti_r - 1'b1;
          bfse_pkg::CH_RIGHT: ti_nxt = (ti_r == TI_LAST) ? '0 : ti_r + 1'b1;
          bfse_pkg::CH_OUT: begin
            emit_nxt  = 1'b1;
            obyte_nxt = tape_rdata[bfse_pkg::BYTE_W-1:0];
          end
          bfse_pkg::CH_IN: begin
            tape_we    = 1'b1;
            tape_wdata = eof_r ? '0 : bfse_pkg::CELL_W'(ib_r);
          end
          bfse_pkg::CH_LBR: begin
            if (cell_zero) begin
              if (at_r == PC_LAST) begin
                err_nxt = 1'b1;
              end else begin
                prog_raddr = at_r + 1'b1;
                p_nxt      = at_r + 1'b1;
                fwd_nxt    = 1'b1;
                dep_nxt    = DW'(1);
              end
            end
          end
          bfse_pkg::CH_RBR: begin
            if (!cell_zero) begin
              if (at_r == '0) begin
                err_nxt = 1'b1;
              end else begin
                prog_raddr = at_r - 1'b1;
                p_nxt      = at_r - 1'b1;
                fwd_nxt    = 1'b0;
                dep_nxt    = DW'(1);
              end
            end
          end
          default: ;
        endcase
      end
      bfse_pkg::ST_SCAN: begin
        // examine the byte at the cursor, issue the next read if needed
        tok_nxt = prog_rdata;
        dep_nxt = scan_dep;
        if (scan_hit) begin
          pc_nxt = fwd_r ? pc_inc(p_r) : p_r + 1'b1;
        end else if (scan_edge) begin
          err_nxt = 1'b1;
        end else begin
          p_nxt      = fwd_r ? p_r + 1'b1 : p_r - 1'b1;
          prog_raddr = p_nxt;
        end
      end
      bfse_pkg::ST_POST: res_vld = 1'b1;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfse_pkg::ST_IDLE;
      pc_r    <= '0;
      ti_r    <= '0;
      steps_r <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      ti_r    <= ti_nxt;
      steps_r <= steps_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    at_r    <= at_nxt;
    p_r     <= p_nxt;
    dep_r   <= dep_nxt;
    fwd_r   <= fwd_nxt;
    emit_r  <= emit_nxt;
    obyte_r <= obyte_nxt;
    tok_r   <= tok_nxt;
    err_r   <= err_nxt;
    if (in_acc) begin
      ld_addr_r <= in_prog_addr;
      ld_byte_r <= in_prog_byte;
      ib_r      <= in_in_byte;
      eof_r     <= in_in_eof;
    end
  end

  assign prog_waddr = wrap_addr(ld_addr_r);
  assign prog_wdata = ld_byte_r;
  assign tape_waddr = ti_r;
  assign tape_raddr = ti_r;

  assign res.emit   = emit_r;
  assign res.obyte  = obyte_r;
  assign res.token  = tok_r;
  assign res.new_pc = bfse_pkg::ADDR_W'(pc_r);
  assign res.steps  = steps_r;
  assign res.err    = err_r;

endmodule

### design/bfse_checker.sv
// ============================================================================
// bfse_checker
// Port-level checks on the step engine's item and result channels, bound to the top.
// ============================================================================
module bfse_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_out_valid,
  input logic [bfse_pkg::BYTE_W-1:0] out_out_byte,
  input logic [bfse_pkg::CNT_W-1:0]  out_step_total,
  input logic                        out_scan_error
);

  logic [bfse_pkg::CNT_W-1:0] last_total_r;
  logic                       out_acc;

  assign out_acc = out_valid && !out_stall;

  // Track the step count of the last delivered word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_total_r <= '0;
    end else if (out_acc) begin
      last_total_r <= out_step_total;
    end
  end

  // Reset empties the result register and holds off items during the fill
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (in_stall && !out_valid))
    else $error("busy or result present right after reset");

  // A stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_step_total)
      && $stable(out_out_byte))
    else $error("stalled result word changed");

  // Step count grows by at most one per delivered word
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (out_step_total == last_total_r)
      || (out_step_total == last_total_r + 1'b1))
    else $error("step count skipped");

  // A word with a scan error does not emit, or emits a zero byte
  a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_scan_error || !out_out_valid) |-> !out_out_valid
      || (out_out_byte == '0))
    else $error("emit flag inconsistent with scan error or byte");

  // Input valid is unknown-free once out of reset
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(in_valid))
    else $error("input valid unknown");

endmodule

bind brainfuck_step_engine bfse_checker u_bfse_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_out_valid  (out_out_valid),
  .out_out_byte   (out_out_byte),
  .out_step_total (out_step_total),
  .out_scan_error (out_scan_error)
);
